FILE: design/url_query_param_splitter_assert.svh
// Assertion macros for the query parameter splitter.
// Used by the top level only; no other dependencies.
`ifndef URL_QUERY_PARAM_SPLITTER_ASSERT_SVH
`define URL_QUERY_PARAM_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// a must be followed in the same cycle by b
`define UPQS_ASSERT_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("implication check failed");
// a must never hold
`define UPQS_ASSERT_NEVER(lbl, a) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(a)) \
    else $error("forbidden condition seen");
`else
`define UPQS_ASSERT_IMPLIES(lbl, a, b)
`define UPQS_ASSERT_NEVER(lbl, a)
`endif
`endif

FILE: design/upqs_pkg.sv
// Shared types and constants of the query parameter splitter.
// No dependencies; imported by every module of the block.
package upqs_pkg;

  localparam int unsigned IDX_W  = 5;
  localparam int unsigned OFS_W  = 11;
  localparam int unsigned KLEN_W = 10;
  localparam int unsigned VLEN_W = 11;
  localparam int unsigned CNT_W  = 5;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_AMP      = 8'h26;

  localparam logic KIND_PARAM   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    PH_SEEK  = 4'b0001,
    PH_KEY   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_e;

  // One queue entry: everything one byte produces (record and/or summary)
  typedef struct packed {
    logic              has_rec;
    logic              has_sum;
    logic [IDX_W-1:0]  param_index;
    logic [OFS_W-1:0]  key_start;
    logic [KLEN_W-1:0] key_length;
    logic [OFS_W-1:0]  value_start;
    logic [VLEN_W-1:0] value_length;
    logic [CNT_W-1:0]  param_count;
    logic              too_long;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: design/upqs_front.sv
// Front end: accepts path bytes, tracks the parse state and builds queue entries.
// Depends on upqs_pkg.
module upqs_front import upqs_pkg::*; #(
  parameter int unsigned MAX_PARAMS     = 20,
  parameter int unsigned MAX_PATH_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       is_final_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  localparam int unsigned PW = $clog2(MAX_PATH_BYTES + 1);
  localparam int unsigned SW = $clog2(MAX_PARAMS + 1);
  localparam logic [PW-1:0] PosLimit = PW'(MAX_PATH_BYTES);
  localparam logic [PW-1:0] LastPos  = PW'(MAX_PATH_BYTES - 1);
  localparam logic [SW-1:0] SlotLast = SW'(MAX_PARAMS - 1);

  function automatic logic [PW-1:0] sat_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  phase_e        phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] fs_q, fs_d;
  logic [PW-1:0] pks_q, pks_d;
  logic [PW-1:0] pkl_q, pkl_d;
  logic [SW-1:0] slot_q, slot_d;
  logic          ovf_q;

  logic          accept;
  logic          hit;
  logic          ovf_now;
  logic [PW-1:0] idx, idx1;
  logic          rec;
  logic [PW-1:0] vlen;

  logic [PW+OFS_W-1:0]  ks_ext, vs_ext;
  logic [PW+KLEN_W-1:0] kl_ext;
  logic [PW+VLEN_W-1:0] vl_ext;
  logic [SW+IDX_W-1:0]  idx_ext;
  logic [SW+CNT_W-1:0]  cnt_ext;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    hit     = (pos_q >= PosLimit);
    idx     = hit ? LastPos : pos_q;
    idx1    = idx + PW'(1);
    pos_d   = hit ? pos_q : pos_q + PW'(1);
    ovf_now = ovf_q | hit;

    phase_d = phase_q;
    fs_d    = fs_q;
    pks_d   = pks_q;
    pkl_d   = pkl_q;
    slot_d  = slot_q;
    rec     = 1'b0;
    vlen    = '0;

    unique case (phase_q)
      PH_SEEK: begin
        if (char_byte_i == CH_QUESTION) begin
          fs_d    = idx1;
          pks_d   = idx1;
          phase_d = PH_KEY;
        end
      end
      PH_KEY: begin
        if (char_byte_i == CH_EQUAL) begin
          pkl_d   = sat_sub(idx, fs_q);
          fs_d    = idx1;
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (char_byte_i == CH_AMP) begin
          // table full: drop the closing slot and stop parsing
          if (slot_q >= SlotLast) begin
            phase_d = PH_STOP;
          end else begin
            rec     = 1'b1;
            vlen    = sat_sub(idx, fs_q);
            slot_d  = slot_q + SW'(1);
            fs_d    = idx1;
            pks_d   = idx1;
            phase_d = PH_KEY;
          end
        end else if (is_final_i) begin
          rec    = 1'b1;
          vlen   = sat_sub(idx1, fs_q);
          slot_d = slot_q + SW'(1);
        end
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idx_ext = {{IDX_W{1'b0}}, slot_q};
    cnt_ext = {{CNT_W{1'b0}}, slot_d};
    ks_ext  = {{OFS_W{1'b0}}, pks_q};
    vs_ext  = {{OFS_W{1'b0}}, fs_q};
    kl_ext  = {{KLEN_W{1'b0}}, pkl_q};
    vl_ext  = {{VLEN_W{1'b0}}, vlen};

    entry_o.has_rec      = rec;
    entry_o.has_sum      = is_final_i;
    entry_o.param_index  = idx_ext[IDX_W-1:0];
    entry_o.key_start    = ks_ext[OFS_W-1:0];
    entry_o.key_length   = kl_ext[KLEN_W-1:0];
    entry_o.value_start  = vs_ext[OFS_W-1:0];
    entry_o.value_length = vl_ext[VLEN_W-1:0];
    entry_o.param_count  = cnt_ext[CNT_W-1:0];
    entry_o.too_long     = ovf_now;
  end

  assign push_o = accept && (rec || is_final_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      pos_q   <= '0;
      fs_q    <= '0;
      pks_q   <= '0;
      pkl_q   <= '0;
      slot_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      // last byte returns the parser to its idle state for the next path
      if (is_final_i) begin
        phase_q <= PH_SEEK;
        pos_q   <= '0;
        fs_q    <= '0;
        pks_q   <= '0;
        pkl_q   <= '0;
        slot_q  <= '0;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        fs_q    <= fs_d;
        pks_q   <= pks_d;
        pkl_q   <= pkl_d;
        slot_q  <= slot_d;
        ovf_q   <= ovf_now;
      end
    end
  end

endmodule

FILE: design/upqs_fifo.sv
// Short entry queue between the parser front end and the output back end.
// Depends on upqs_pkg.
module upqs_fifo import upqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  entry_t     push_data_i,
  input  logic       pop_i,
  output entry_t     pop_data_o,
  output fifo_stat_t stat_o
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: design/upqs_back.sv
// Back end: takes queue entries and sends the record and summary words out.
// Depends on upqs_pkg.
module upqs_back import upqs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  entry_t cur_q;
  logic   rec_q, sum_q;
  logic   hs, load;

  assign hs   = m_axis_tvalid && m_axis_tready;
  // refill when nothing is held or the last pending word leaves now
  assign load = !(rec_q || sum_q) || (hs && (rec_q ^ sum_q));
  assign pop_o = load && valid_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= 1'b0;
      sum_q <= 1'b0;
    end else if (load) begin
      rec_q <= valid_i && entry_i.has_rec;
      sum_q <= valid_i && entry_i.has_sum;
    end else if (hs) begin
      rec_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = rec_q || sum_q;
  assign m_axis_tuser  = rec_q ? KIND_PARAM : KIND_SUMMARY;
  assign m_axis_tlast  = rec_q ? !sum_q : 1'b1;

  always_comb begin
    if (rec_q) begin
      m_axis_tdata = {2'b00, cur_q.too_long, {CNT_W{1'b0}}, cur_q.value_length,
                      cur_q.value_start, cur_q.key_length, cur_q.key_start,
                      cur_q.param_index};
    end else begin
      m_axis_tdata = {2'b00, cur_q.too_long, cur_q.param_count, {VLEN_W{1'b0}},
                      {OFS_W{1'b0}}, {KLEN_W{1'b0}}, {OFS_W{1'b0}}, {IDX_W{1'b0}}};
    end
  end

endmodule

FILE: design/url_query_param_splitter.sv
// Query parameter splitter: one path byte per cycle in, parameter records and
// an end-of-path summary out. A result word is written into the queue when its
// byte is taken and then loaded into the output register; bytes are taken
// every cycle while the 4-entry queue has room. A last byte closing a value
// gives two words. Reset (asynchronous, active low) clears the parser state,
// the queue and the output valid; the block is ready as soon as reset is released.
module url_query_param_splitter import upqs_pkg::*; #(
  parameter int unsigned MAX_PARAMS     = 20,
  parameter int unsigned MAX_PATH_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
  input  logic        s_axis_tlast,  // is_final
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] param_index, [15:5] key_start, [25:16] key_length, [36:26] value_start,
  // [47:37] value_length, [52:48] param_count, [53] too_long, [55:54] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] kind
  output logic        m_axis_tlast   // end_of_run
);

`include "url_query_param_splitter_assert.svh"

  entry_t     push_entry, pop_entry;
  logic       push, pop;
  fifo_stat_t qstat;

  upqs_front #(
    .MAX_PARAMS     (MAX_PARAMS),
    .MAX_PATH_BYTES (MAX_PATH_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .char_byte_i (s_axis_tdata),
    .is_final_i  (s_axis_tlast),
    .full_i      (qstat.full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  upqs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .stat_o      (qstat)
  );

  upqs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!qstat.empty),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `UPQS_ASSERT_NEVER(a_no_push_when_full, push && qstat.full)
  `UPQS_ASSERT_NEVER(a_full_and_empty, qstat.full && qstat.empty)
  `UPQS_ASSERT_IMPLIES(a_summary_ends_run, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY), m_axis_tlast)
  `UPQS_ASSERT_IMPLIES(a_pop_needs_entry, pop, !qstat.empty)

endmodule

FILE: dv/url_query_param_splitter_tb.sv
// Self-checking testbench for url_query_param_splitter: drives path bytes on the
// input stream and checks every record and summary word against a local predictor.
// Depends on upqs_pkg and the url_query_param_splitter RTL only.
module url_query_param_splitter_tb import upqs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SLOTS    = 20;
  localparam int unsigned MAX_BYTES    = 1024;
  localparam int unsigned ITEM_TARGET  = 1800;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  slot;
    logic [OFS_W-1:0]  key_start;
    logic [KLEN_W-1:0] key_len;
    logic [OFS_W-1:0]  val_start;
    logic [VLEN_W-1:0] val_len;
    logic [CNT_W-1:0]  count;
    logic              too_long;
    logic              run_end;
  } query_word_t;

  class query_scoreboard;
    query_word_t words_due[$];
    phase_e      phase;
    int unsigned pos;
    int unsigned field_start;
    int unsigned key_start;
    int unsigned key_len;
    int unsigned slot;
    bit          overflowed;
    int unsigned errors;
    int unsigned records_seen;
    int unsigned summaries_seen;
    int unsigned full_stops;
    int unsigned long_paths;

    function new();
      errors = 0;
      records_seen = 0;
      summaries_seen = 0;
      full_stops = 0;
      long_paths = 0;
      restart();
    endfunction

    function void restart();
      phase       = PH_SEEK;
      pos         = 0;
      field_start = 0;
      key_start   = 0;
      key_len     = 0;
      slot        = 0;
      overflowed  = 1'b0;
    endfunction

    function int unsigned floor_sub(int unsigned a, int unsigned b);
      return (a > b) ? a - b : 0;
    endfunction

    function void push_record(int unsigned vlen);
      query_word_t w;
      w           = '0;
      w.kind      = KIND_PARAM;
      w.slot      = IDX_W'(slot);
      w.key_start = OFS_W'(key_start);
      w.key_len   = KLEN_W'(key_len);
      w.val_start = OFS_W'(field_start);
      w.val_len   = VLEN_W'(vlen);
      w.too_long  = overflowed;
      words_due.push_back(w);
    endfunction

    // Predict the words caused by one accepted path byte
    function void note_byte(logic [7:0] ch, logic fin);
      int unsigned at;
      int unsigned before_cnt;
      query_word_t w;
      before_cnt = words_due.size();
      // saturate offsets past the length limit
      if (pos >= MAX_BYTES) begin
        overflowed = 1'b1;
        at = MAX_BYTES - 1;
      end else begin
        at = pos;
        pos++;
      end
      case (phase)
        PH_SEEK: begin
          if (ch == CH_QUESTION) begin
            field_start = at + 1;
            key_start   = at + 1;
            phase       = PH_KEY;
          end
        end
        PH_KEY: begin
          if (ch == CH_EQUAL) begin
            key_len     = floor_sub(at, field_start);
            field_start = at + 1;
            phase       = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (ch == CH_AMP) begin
            if (slot + 1 >= MAX_SLOTS) begin
              phase = PH_STOP;
              full_stops++;
            end else begin
              push_record(floor_sub(at, field_start));
              slot++;
              field_start = at + 1;
              key_start   = at + 1;
              phase       = PH_KEY;
            end
          end else if (fin) begin
            push_record(floor_sub(at + 1, field_start));
            slot++;
          end
        end
        default: ;
      endcase
      if (fin) begin
        w          = '0;
        w.kind     = KIND_SUMMARY;
        w.count    = CNT_W'(slot);
        w.too_long = overflowed;
        w.run_end  = 1'b1;
        words_due.push_back(w);
        if (overflowed) long_paths++;
        restart();
      end else if (words_due.size() > before_cnt) begin
        // mark the last word of this byte
        w = words_due.pop_back();
        w.run_end = 1'b1;
        words_due.push_back(w);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(logic [55:0] data, logic user, logic last);
      query_word_t want;
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual kind %0d data %h",
                 $time, user, data);
        return;
      end
      want = words_due.pop_front();
      compare_field("kind", want.kind, user);
      compare_field("param_index", want.slot, data[4:0]);
      compare_field("key_start", want.key_start, data[15:5]);
      compare_field("key_length", want.key_len, data[25:16]);
      compare_field("value_start", want.val_start, data[36:26]);
      compare_field("value_length", want.val_len, data[47:37]);
      compare_field("param_count", want.count, data[52:48]);
      compare_field("too_long", want.too_long, data[53]);
      compare_field("pad bits", 0, data[55:54]);
      compare_field("end_of_run", want.run_end, last);
      if (user == KIND_SUMMARY) summaries_seen++;
      else records_seen++;
    endfunction

    function int unsigned pending_count();
      return words_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  query_scoreboard sb;
  logic [7:0]      path_q[$];
  int unsigned     items_sent;
  int unsigned     words_taken;
  int unsigned     cycle_count;
  bit              tx_quiet;
  bit              rx_quiet;

  url_query_param_splitter #(
    .MAX_PARAMS    (MAX_SLOTS),
    .MAX_PATH_BYTES(MAX_BYTES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("url_query_param_splitter regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, fin);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++) send_byte(path_q[i], i == path_q.size() - 1);
  endtask

  function automatic logic [7:0] pick_content();
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic void add_field(int unsigned len);
    repeat (len) path_q.push_back(pick_content());
  endfunction

  // Query of pairs with random content, now and then cut short
  function automatic void build_query_path();
    int unsigned npairs;
    int unsigned cut;
    path_q.delete();
    repeat ($urandom_range(0, 3)) path_q.push_back(8'($urandom_range(8'h40, 8'h7E)));
    path_q.push_back(CH_QUESTION);
    npairs = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 23) : $urandom_range(0, 5);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) path_q.push_back(CH_AMP);
      add_field($urandom_range(0, 3));
      path_q.push_back(CH_EQUAL);
      add_field($urandom_range(0, 4));
    end
    case ($urandom_range(0, 3))
      1: path_q.push_back(CH_AMP);
      2: begin
        path_q.push_back(CH_AMP);
        add_field($urandom_range(1, 3));
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, path_q.size());
      while (path_q.size() > cut) void'(path_q.pop_back());
    end
  endfunction

  function automatic void build_noise_path();
    path_q.delete();
    repeat ($urandom_range(1, 12)) path_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Runs past the length limit with pairs straddling it
  function automatic void build_long_path();
    path_q.delete();
    path_q.push_back(CH_QUESTION);
    while (path_q.size() < 1100) begin
      add_field($urandom_range(1, 3));
      path_q.push_back(CH_EQUAL);
      repeat ($urandom_range(30, 200)) path_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      path_q.push_back(CH_AMP);
    end
    path_q.push_back(8'h7A);
  endfunction

  // Result side: random stalls plus an occasional long hold-off
  initial begin
    int unsigned gap;
    int unsigned next_hold;
    m_axis_tready = 1'b0;
    words_taken   = 0;
    rx_quiet      = 1'b0;
    next_hold     = 40;
    @(posedge rst_ni);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 3);
      if (words_taken >= next_hold) begin
        gap = HOLD_CYCLES;
        next_hold += 560;
      end
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      words_taken++;
      if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
    end
  end

  initial begin
    bit long_done;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    items_sent    = 0;
    tx_quiet      = 1'b0;
    long_done     = 1'b0;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // byte extremes as lone last bytes before any '?'
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // '&' in a key, '=' and a second '?' in a value, last byte inside a key
    send_text("x?a&=v=?&q");
    // last byte on '=' leaves an unfinished pair
    send_text("?k=");
    // empty key, value closed by the last byte
    send_text("?=v");
    // last byte '&' closes a pair and ends the path
    send_text("?=&");

    while (items_sent < ITEM_TARGET) begin
      if (!long_done && items_sent > 400) begin
        build_long_path();
        long_done = 1'b1;
      end else if ($urandom_range(0, 6) == 0) begin
        build_noise_path();
      end else begin
        build_query_path();
      end
      tx_quiet = ($urandom_range(0, 4) == 0);
      send_path();
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d path bytes; checked %0d parameter records and %0d summaries.",
             items_sent, sb.records_seen, sb.summaries_seen);
    $display("Table-full stops: %0d, over-long paths: %0d.", sb.full_stops, sb.long_paths);
    if (sb.errors == 0) begin
      $display("url_query_param_splitter regression: pass");
    end else begin
      $display("url_query_param_splitter regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/upqs_pkg.sv
design/upqs_front.sv
design/upqs_fifo.sv
design/upqs_back.sv
design/url_query_param_splitter.sv
dv/url_query_param_splitter_tb.sv
